[rtl/video_register_raster_irq_defines.svh]
// Assertion macros for the raster interrupt register block.
`ifndef VIDEO_REGISTER_RASTER_IRQ_DEFINES_SVH
`define VIDEO_REGISTER_RASTER_IRQ_DEFINES_SVH

`ifndef ASSERT_OFF
// Condition that must hold at every clock edge outside reset
`define VRIRQ_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// Condition in one cycle that implies another in the next cycle
`define VRIRQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define VRIRQ_ASSERT_ALWAYS(label, clk, rst, cond, msg)
`define VRIRQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

[rtl/vrirq_pkg.sv]
// Types and constants shared by the raster interrupt register block.
package vrirq_pkg;

   // Request kinds
   typedef enum logic [1:0] {
      REQ_TICK  = 2'd0,
      REQ_READ  = 2'd1,
      REQ_WRITE = 2'd2,
      REQ_HIT   = 2'd3
   } req_kind_type;

   localparam int RegDepth   = 64;
   localparam int AddrWidth  = 6;
   localparam int LineWidth  = 9;
   localparam int CycleWidth = 6;

   // Register offsets with special behaviour
   localparam logic [AddrWidth-1:0] OFS_CTRL     = 6'h11;
   localparam logic [AddrWidth-1:0] OFS_LINE     = 6'h12;
   localparam logic [AddrWidth-1:0] OFS_STATUS   = 6'h19;
   localparam logic [AddrWidth-1:0] OFS_MASK     = 6'h1A;
   localparam logic [AddrWidth-1:0] OFS_SPR_HIT  = 6'h1E;
   localparam logic [AddrWidth-1:0] OFS_BACK_HIT = 6'h1F;

   // Interrupt status codes
   localparam logic [7:0] IRQ_RASTER   = 8'h81;
   localparam logic [7:0] IRQ_SRC_MASK = 8'h07;

   typedef struct packed {
      req_kind_type          req_type;
      logic [AddrWidth-1:0]  reg_addr;
      logic [7:0]            write_data;
      logic [7:0]            sprite_sprite_hits;
      logic [7:0]            sprite_back_hits;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]             read_data;
      logic                   irq_out;
      logic [LineWidth-1:0]   current_line;
      logic [CycleWidth-1:0]  current_cycle;
   } rsp_payload_type;

endpackage

[rtl/vrirq_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module vrirq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port, holds while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/video_register_raster_irq.sv]
// A taken request waits in the input register, then moves into the result register.
// One request per cycle unless stalled; the register file RAM is read on acceptance.
// Stalling the result side holds the input register and then stalls the request side.
// Reset (synchronous) clears counters, status, latches and the 64 per-entry valid flags
// at once, so no clearing pass is needed and requests are taken the cycle after reset.
`include "video_register_raster_irq_defines.svh"

module video_register_raster_irq #(
   parameter int CYCLES_PER_LINE = 63,
   parameter int LINES_PER_FRAME = 312
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  vrirq_pkg::req_payload_type req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output vrirq_pkg::rsp_payload_type rsp_payload
);

   import vrirq_pkg::*;

   localparam logic [CycleWidth:0] CplLimit = (CycleWidth + 1)'(CYCLES_PER_LINE);
   localparam logic [LineWidth:0]  LpfLimit = (LineWidth + 1)'(LINES_PER_FRAME);

   // Pipeline registers
   logic            req_valid_ff;
   req_payload_type req_ff;
   logic            rsp_valid_ff;
   rsp_payload_type rsp_ff, rsp_in;
   logic            advance;
   logic            req_take;

   // Block state
   logic [LineWidth-1:0]  compare_ff, compare_in;
   logic [7:0]            status_ff, status_in;
   logic                  pending_ff, pending_in;
   logic [7:0]            spr_latch_ff, spr_latch_in;
   logic [7:0]            back_latch_ff, back_latch_in;
   logic [LineWidth-1:0]  line_ff, line_in;
   logic [CycleWidth-1:0] cycle_ff, cycle_in;
   logic [7:0]            ctrl_ff, ctrl_in;
   logic [7:0]            line_reg_ff, line_reg_in;
   logic [7:0]            mask_ff, mask_in;

   // Register file RAM, valid flags and last-write bypass
   logic [RegDepth-1:0]  ram_valid_ff;
   logic                 ram_we;
   logic [7:0]           ram_rd_data;
   logic                 byp_valid_ff;
   logic [AddrWidth-1:0] byp_addr_ff;
   logic [7:0]           byp_data_ff;
   logic [7:0]           stored_byte;

   logic [CycleWidth:0]  cyc_inc;
   logic [LineWidth:0]   line_inc;

   // Handshake: the input register drains whenever the result register can take it
   assign advance   = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = req_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   vrirq_ram #(
      .WIDTH (8),
      .DEPTH (RegDepth)
   ) u_regfile (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (req_ff.reg_addr),
      .wr_data (req_ff.write_data),
      .rd_en   (req_take),
      .rd_addr (req_payload.reg_addr),
      .rd_data (ram_rd_data)
   );

   // Stored register byte: newest write wins, never-written entries read zero
   always_comb begin
      if (byp_valid_ff && byp_addr_ff == req_ff.reg_addr) begin
         stored_byte = byp_data_ff;
      end else if (ram_valid_ff[req_ff.reg_addr]) begin
         stored_byte = ram_rd_data;
      end else begin
         stored_byte = 8'h00;
      end
   end

   // Request processing
   always_comb begin
      compare_in    = compare_ff;
      status_in     = status_ff;
      pending_in    = pending_ff;
      spr_latch_in  = spr_latch_ff;
      back_latch_in = back_latch_ff;
      line_in       = line_ff;
      cycle_in      = cycle_ff;
      ctrl_in       = ctrl_ff;
      line_reg_in   = line_reg_ff;
      mask_in       = mask_ff;
      ram_we        = 1'b0;
      rsp_in        = rsp_ff;
      rsp_in.read_data = 8'h00;
      cyc_inc       = {1'b0, cycle_ff} + (CycleWidth + 1)'(1);
      line_inc      = {1'b0, line_ff} + (LineWidth + 1)'(1);

      if (advance) begin
         case (req_ff.req_type)
            REQ_TICK: begin
               if (cyc_inc >= CplLimit) begin
                  cycle_in = '0;
                  if (line_inc >= LpfLimit) begin
                     line_in = '0;
                  end else begin
                     line_in = line_inc[LineWidth-1:0];
                  end
               end else begin
                  cycle_in = cyc_inc[CycleWidth-1:0];
               end
               // mirror the raster line into the line and control registers
               line_reg_in = line_in[7:0];
               ctrl_in     = {line_in[8], ctrl_ff[6:0]};
               if (line_in == compare_ff && mask_ff[0]) begin
                  status_in  = IRQ_RASTER;
                  pending_in = 1'b1;
               end
            end
            REQ_READ: begin
               if (req_ff.reg_addr == OFS_STATUS) begin
                  rsp_in.read_data = status_ff;
               end else if (req_ff.reg_addr == OFS_SPR_HIT) begin
                  rsp_in.read_data = spr_latch_ff;
                  spr_latch_in     = 8'h00;
               end else if (req_ff.reg_addr == OFS_BACK_HIT) begin
                  rsp_in.read_data = back_latch_ff;
                  back_latch_in    = 8'h00;
               end else if (req_ff.reg_addr == OFS_CTRL) begin
                  rsp_in.read_data = ctrl_ff;
               end else if (req_ff.reg_addr == OFS_LINE) begin
                  rsp_in.read_data = line_reg_ff;
               end else if (req_ff.reg_addr == OFS_MASK) begin
                  rsp_in.read_data = mask_ff;
               end else begin
                  rsp_in.read_data = stored_byte;
               end
            end
            REQ_WRITE: begin
               if (req_ff.reg_addr == OFS_STATUS) begin
                  // acknowledge: clear written bits, drop the line when no source is left
                  status_in = status_ff & ~req_ff.write_data;
                  if ((status_in & IRQ_SRC_MASK) == 8'h00) begin
                     status_in  = 8'h00;
                     pending_in = 1'b0;
                  end
               end else if (req_ff.reg_addr == OFS_SPR_HIT) begin
                  spr_latch_in = req_ff.write_data;
               end else if (req_ff.reg_addr == OFS_BACK_HIT) begin
                  back_latch_in = req_ff.write_data;
               end else begin
                  ram_we = 1'b1;
                  if (req_ff.reg_addr == OFS_CTRL) begin
                     ctrl_in    = req_ff.write_data;
                     compare_in = {req_ff.write_data[7], compare_ff[7:0]};
                  end
                  if (req_ff.reg_addr == OFS_LINE) begin
                     line_reg_in = req_ff.write_data;
                     compare_in  = {compare_ff[8], req_ff.write_data};
                  end
                  if (req_ff.reg_addr == OFS_MASK) begin
                     mask_in = req_ff.write_data;
                  end
               end
            end
            REQ_HIT: begin
               spr_latch_in  = spr_latch_ff | req_ff.sprite_sprite_hits;
               back_latch_in = back_latch_ff | req_ff.sprite_back_hits;
            end
            default: begin
            end
         endcase
         rsp_in.irq_out       = pending_in;
         rsp_in.current_line  = line_in;
         rsp_in.current_cycle = cycle_in;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         compare_ff    <= '0;
         status_ff     <= 8'h00;
         pending_ff    <= 1'b0;
         spr_latch_ff  <= 8'h00;
         back_latch_ff <= 8'h00;
         line_ff       <= '0;
         cycle_ff      <= '0;
         ctrl_ff       <= 8'h00;
         line_reg_ff   <= 8'h00;
         mask_ff       <= 8'h00;
         ram_valid_ff  <= '0;
         byp_valid_ff  <= 1'b0;
      end else begin
         if (req_take) begin
            req_valid_ff <= 1'b1;
         end else if (advance) begin
            req_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         compare_ff    <= compare_in;
         status_ff     <= status_in;
         pending_ff    <= pending_in;
         spr_latch_ff  <= spr_latch_in;
         back_latch_ff <= back_latch_in;
         line_ff       <= line_in;
         cycle_ff      <= cycle_in;
         ctrl_ff       <= ctrl_in;
         line_reg_ff   <= line_reg_in;
         mask_ff       <= mask_in;
         if (ram_we) begin
            ram_valid_ff[req_ff.reg_addr] <= 1'b1;
            byp_valid_ff                  <= 1'b1;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff <= req_payload;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
      if (ram_we) begin
         byp_addr_ff <= req_ff.reg_addr;
         byp_data_ff <= req_ff.write_data;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Checks
   `VRIRQ_ASSERT_ALWAYS(a_pending_status, clock, reset, pending_ff == (status_ff != 8'h00), "interrupt line and status disagree")
   `VRIRQ_ASSERT_ALWAYS(a_counter_range, clock, reset, ({1'b0, cycle_ff} < CplLimit) && ({1'b0, line_ff} < LpfLimit), "raster counter out of range")
   `VRIRQ_ASSERT_NEXT(a_read_data_zero, clock, reset, advance && req_ff.req_type != REQ_READ, rsp_ff.read_data == 8'h00, "read data set for a non-read request")

endmodule

[bench/raster_irq_checker.sv]
// Checker for the raster interrupt register block: predicts each reply and compares it.
`timescale 1ns / 100ps

module raster_irq_checker #(
   parameter int CYCLES_PER_LINE = 63,
   parameter int LINES_PER_FRAME = 312
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  vrirq_pkg::req_payload_type req_payload,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  vrirq_pkg::rsp_payload_type rsp_payload,
   output int                         fail_count,
   output int                         outstanding
);

   import vrirq_pkg::*;

   // Predicted chip state
   logic [7:0]            reg_mem [RegDepth];
   logic [LineWidth-1:0]  cmp_line;
   logic [LineWidth-1:0]  line_cnt;
   logic [CycleWidth-1:0] cyc_cnt;
   logic [7:0]            irq_stat;
   logic                  irq_line;
   logic [7:0]            spr_latch;
   logic [7:0]            back_latch;

   // Replies predicted for accepted requests, oldest first
   rsp_payload_type predicted_reply_q[$];

   // Apply one request to the predicted state and return the reply it gives
   function automatic rsp_payload_type raster_apply(input req_payload_type r);
      rsp_payload_type o;
      int              nxt_cyc;
      int              nxt_line;
      o = '0;
      case (r.req_type)
         REQ_TICK: begin
            nxt_cyc  = int'(cyc_cnt) + 1;
            nxt_line = int'(line_cnt);
            if (nxt_cyc >= CYCLES_PER_LINE) begin
               nxt_cyc = 0;
               nxt_line++;
               if (nxt_line >= LINES_PER_FRAME) nxt_line = 0;
            end
            cyc_cnt  = CycleWidth'(nxt_cyc);
            line_cnt = LineWidth'(nxt_line);
            // raster line mirrored into the line register and control bit 7
            reg_mem[OFS_LINE]    = line_cnt[7:0];
            reg_mem[OFS_CTRL][7] = line_cnt[8];
            // compare is checked on every tick of the matching line
            if (line_cnt == cmp_line && reg_mem[OFS_MASK][0]) begin
               irq_stat = IRQ_RASTER;
               irq_line = 1'b1;
            end
         end
         REQ_READ: begin
            case (r.reg_addr)
               OFS_STATUS: o.read_data = irq_stat;
               OFS_SPR_HIT: begin
                  o.read_data = spr_latch;
                  spr_latch   = '0;
               end
               OFS_BACK_HIT: begin
                  o.read_data = back_latch;
                  back_latch  = '0;
               end
               default: o.read_data = reg_mem[r.reg_addr];
            endcase
         end
         REQ_WRITE: begin
            if (r.reg_addr == OFS_STATUS) begin
               // acknowledge: clear written bits, drop the line once no source remains
               irq_stat = irq_stat & ~r.write_data;
               if ((irq_stat & IRQ_SRC_MASK) == '0) begin
                  irq_stat = '0;
                  irq_line = 1'b0;
               end
            end else if (r.reg_addr == OFS_SPR_HIT) begin
               spr_latch = r.write_data;
            end else if (r.reg_addr == OFS_BACK_HIT) begin
               back_latch = r.write_data;
            end else begin
               if (r.reg_addr == OFS_CTRL) cmp_line[8] = r.write_data[7];
               if (r.reg_addr == OFS_LINE) cmp_line[7:0] = r.write_data;
               reg_mem[r.reg_addr] = r.write_data;
            end
         end
         default: begin
            spr_latch  = spr_latch | r.sprite_sprite_hits;
            back_latch = back_latch | r.sprite_back_hits;
         end
      endcase
      o.irq_out       = irq_line;
      o.current_line  = line_cnt;
      o.current_cycle = cyc_cnt;
      return o;
   endfunction

   function automatic void check_field(input string field, input logic [15:0] want,
                                       input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %0h, got %0h", $time, field, want, got);
         fail_count++;
      end
   endfunction

   // Replies are compared before the request of the same edge is predicted
   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         foreach (reg_mem[i]) reg_mem[i] = '0;
         cmp_line   = '0;
         line_cnt   = '0;
         cyc_cnt    = '0;
         irq_stat   = '0;
         irq_line   = 1'b0;
         spr_latch  = '0;
         back_latch = '0;
         predicted_reply_q.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (predicted_reply_q.size() == 0) begin
               $display("%0t: reply with no request outstanding: expected none, got %h",
                        $time, rsp_payload);
               fail_count++;
            end else begin
               want = predicted_reply_q.pop_front();
               check_field("read_data", 16'(want.read_data), 16'(rsp_payload.read_data));
               check_field("irq_out", 16'(want.irq_out), 16'(rsp_payload.irq_out));
               check_field("current_line", 16'(want.current_line),
                           16'(rsp_payload.current_line));
               check_field("current_cycle", 16'(want.current_cycle),
                           16'(rsp_payload.current_cycle));
            end
         end
         if (req_valid && !req_stall) predicted_reply_q.push_back(raster_apply(req_payload));
      end
      outstanding = predicted_reply_q.size();
   end

endmodule

[bench/testbench.sv]
// Top of the raster interrupt register block bench: clock, reset, request traffic, verdict.
`timescale 1ns / 100ps

module testbench;
   import vrirq_pkg::*;

   localparam int CyclesPerLine = 63;
   localparam int LinesPerFrame = 312;
   localparam int RandomItems   = 920;
   localparam int HoldOffCycles = 200;
   localparam int IdleLimit     = 2000;
   localparam int TailCycles    = 8;

   logic            clock = 1'b0;
   logic            reset;
   logic            req_valid;
   logic            req_stall;
   req_payload_type req_payload;
   logic            rsp_valid;
   logic            rsp_stall;
   rsp_payload_type rsp_payload;
   int              fail_count;
   int              outstanding;
   int              idle_cycles = 0;
   int              quiet_left  = 0;
   bit              hold_off_go = 1'b0;

   always #5 clock = ~clock;

   video_register_raster_irq #(
      .CYCLES_PER_LINE(CyclesPerLine),
      .LINES_PER_FRAME(LinesPerFrame)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

   raster_irq_checker #(
      .CYCLES_PER_LINE(CyclesPerLine),
      .LINES_PER_FRAME(LinesPerFrame)
   ) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload),
      .fail_count (fail_count),
      .outstanding(outstanding)
   );

   function automatic req_payload_type make_req(input req_kind_type kind,
                                                input logic [AddrWidth-1:0] addr,
                                                input logic [7:0] data,
                                                input logic [7:0] spr_hits,
                                                input logic [7:0] back_hits);
      req_payload_type p;
      p.req_type           = kind;
      p.reg_addr           = addr;
      p.write_data         = data;
      p.sprite_sprite_hits = spr_hits;
      p.sprite_back_hits   = back_hits;
      return p;
   endfunction

   // Mostly short gaps, a few long ones, and now and then a run with none
   function automatic int sender_gap();
      int unsigned roll;
      if (quiet_left > 0) begin
         quiet_left--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
         quiet_left = $urandom_range(30, 80);
         return 0;
      end
      if (roll < 50) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Random request of any kind
   function automatic req_payload_type random_req();
      req_payload_type p;
      int unsigned     roll;
      p.reg_addr           = AddrWidth'($urandom);
      p.write_data         = 8'($urandom);
      p.sprite_sprite_hits = 8'($urandom);
      p.sprite_back_hits   = 8'($urandom);
      roll = $urandom_range(0, 99);
      if (roll < 45) p.req_type = REQ_TICK;
      else if (roll < 70) p.req_type = REQ_READ;
      else if (roll < 90) p.req_type = REQ_WRITE;
      else p.req_type = REQ_HIT;
      // half the accesses land on registers with side effects
      if ($urandom_range(0, 1) == 0) begin
         case ($urandom_range(0, 5))
            0: p.reg_addr = OFS_CTRL;
            1: p.reg_addr = OFS_LINE;
            2: p.reg_addr = OFS_STATUS;
            3: p.reg_addr = OFS_MASK;
            4: p.reg_addr = OFS_SPR_HIT;
            default: p.reg_addr = OFS_BACK_HIT;
         endcase
      end
      if (p.req_type == REQ_WRITE) begin
         // keep the compare near the early lines so raster hits happen
         case (p.reg_addr)
            OFS_LINE: if ($urandom_range(0, 3) != 0) p.write_data = 8'($urandom_range(0, 15));
            OFS_CTRL: if ($urandom_range(0, 3) != 0) p.write_data[7] = 1'b0;
            OFS_MASK: if ($urandom_range(0, 3) != 0) p.write_data[0] = 1'b1;
            default: ;
         endcase
      end
      return p;
   endfunction

   task automatic send_req(input req_payload_type p);
      int gap;
      req_valid   <= 1'b1;
      req_payload <= p;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      gap = sender_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Request side
   initial begin
      int i;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_payload <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: interrupt raise and acknowledge, compare writes, latches, address extremes
      send_req(make_req(REQ_TICK, '0, '0, '0, '0));
      send_req(make_req(REQ_READ, OFS_STATUS, '0, '0, '0));
      send_req(make_req(REQ_WRITE, OFS_MASK, 8'h01, '0, '0));
      send_req(make_req(REQ_TICK, '0, '0, '0, '0));
      send_req(make_req(REQ_READ, OFS_STATUS, '0, '0, '0));
      send_req(make_req(REQ_WRITE, OFS_STATUS, 8'h80, '0, '0));
      send_req(make_req(REQ_WRITE, OFS_STATUS, 8'h01, '0, '0));
      send_req(make_req(REQ_TICK, '0, '0, '0, '0));
      send_req(make_req(REQ_WRITE, OFS_STATUS, 8'hFF, '0, '0));
      send_req(make_req(REQ_WRITE, OFS_LINE, 8'hFF, '0, '0));
      send_req(make_req(REQ_WRITE, OFS_CTRL, 8'h80, '0, '0));
      send_req(make_req(REQ_READ, OFS_CTRL, '0, '0, '0));
      send_req(make_req(REQ_TICK, '0, '0, '0, '0));
      send_req(make_req(REQ_READ, OFS_CTRL, '0, '0, '0));
      send_req(make_req(REQ_READ, OFS_LINE, '0, '0, '0));
      send_req(make_req(REQ_HIT, '0, '0, 8'hFF, 8'hAA));
      send_req(make_req(REQ_HIT, '0, '0, 8'h00, 8'h55));
      send_req(make_req(REQ_READ, OFS_SPR_HIT, '0, '0, '0));
      send_req(make_req(REQ_READ, OFS_BACK_HIT, '0, '0, '0));
      send_req(make_req(REQ_WRITE, OFS_SPR_HIT, 8'h5A, '0, '0));
      send_req(make_req(REQ_WRITE, OFS_BACK_HIT, 8'hA5, '0, '0));
      send_req(make_req(REQ_READ, 6'h3F, '0, '0, '0));
      send_req(make_req(REQ_WRITE, 6'h3F, 8'hFF, '0, '0));
      send_req(make_req(REQ_READ, 6'h3F, '0, '0, '0));
      send_req(make_req(REQ_WRITE, 6'h00, 8'h00, '0, '0));

      // Random mix; the long receiver hold-off starts a third of the way in
      for (i = 0; i < RandomItems; i++) begin
         if (i == RandomItems / 3) hold_off_go = 1'b1;
         send_req(random_req());
      end

      // Drain and give the verdict; one edge first so the last request is counted
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (TailCycles) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("video_register_raster_irq regression: pass");
      end else begin
         $display("video_register_raster_irq regression: fail");
      end
      $finish;
   end

   // Reply side: alternating stall and go runs, plus one long hold-off
   initial begin
      bit stall_now;
      bit hold_off_done;
      int run_left;
      stall_now     = 1'b0;
      hold_off_done = 1'b0;
      run_left      = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_go && !hold_off_done) begin
            stall_now     = 1'b1;
            run_left      = HoldOffCycles;
            hold_off_done = 1'b1;
         end else if (run_left <= 0) begin
            stall_now = !stall_now;
            if (stall_now)
               run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                      : $urandom_range(1, 3);
            else
               run_left = ($urandom_range(0, 19) == 0) ? $urandom_range(50, 150)
                                                       : $urandom_range(1, 12);
         end
         rsp_stall <= stall_now;
         run_left--;
      end
   end

   // Watchdog: too long without any request or reply taken
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("video_register_raster_irq regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

[sim.f]
+incdir+rtl
rtl/vrirq_pkg.sv
rtl/vrirq_ram.sv
rtl/video_register_raster_irq.sv
bench/raster_irq_checker.sv
bench/testbench.sv
